[hdl/pbp_pkg.sv]
// pbp_pkg: shared types, constants and helper functions of the perceptron predictor
package pbp_pkg;

   localparam int TABLE_ENTRIES  = 64;   // power of two, the table index is the low address bits
   localparam int HISTORY_LENGTH = 8;
   localparam int WEIGHT_BITS    = 8;
   localparam int ADDR_BITS      = 32;
   localparam int THR_BITS       = 8;
   localparam int OUT_BITS       = 12;
   localparam int IDX_BITS       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SUM_BITS       = WEIGHT_BITS + $clog2(HISTORY_LENGTH + 1);
   localparam int WIDE_BITS      = SUM_BITS + OUT_BITS;

   localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(30);

   typedef logic signed [WEIGHT_BITS-1:0] weight_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [OUT_BITS-1:0]    shown_type;
   typedef logic [IDX_BITS-1:0]           idx_type;
   typedef logic [HISTORY_LENGTH-1:0]     hist_type;
   typedef logic [THR_BITS-1:0]           thr_type;

   // one table row: the bias and all weights of one perceptron
   typedef struct packed {
      weight_type                       bias;
      weight_type [HISTORY_LENGTH-1:0]  weight;
   } row_type;

   // status from the perceptron datapath to the sequencer
   typedef struct packed {
      logic pred;
      logic train;
   } verdict_type;

   localparam weight_type WEIGHT_MAX = weight_type'((1 << (WEIGHT_BITS - 1)) - 1);
   localparam weight_type WEIGHT_MIN = weight_type'(-(1 << (WEIGHT_BITS - 1)));

   localparam logic signed [WIDE_BITS-1:0] SHOWN_MAX_W = WIDE_BITS'((1 << (OUT_BITS - 1)) - 1);
   localparam logic signed [WIDE_BITS-1:0] SHOWN_MIN_W = WIDE_BITS'(-(1 << (OUT_BITS - 1)));

   // one saturating step up or down
   function automatic weight_type sat_step(weight_type w, logic up);
      weight_type r;
      r = w;
      if (up) begin
         if (w != WEIGHT_MAX) r = w + weight_type'(1);
      end else begin
         if (w != WEIGHT_MIN) r = w - weight_type'(1);
      end
      return r;
   endfunction

   // clamp the exact sum into the output field
   function automatic shown_type clamp_sum(sum_type s);
      logic signed [WIDE_BITS-1:0] w;
      shown_type r;
      w = WIDE_BITS'(s);
      if (w > SHOWN_MAX_W)      r = SHOWN_MAX_W[OUT_BITS-1:0];
      else if (w < SHOWN_MIN_W) r = SHOWN_MIN_W[OUT_BITS-1:0];
      else                      r = w[OUT_BITS-1:0];
      return r;
   endfunction

endpackage

[hdl/pbp_if.sv]
// pbp_if: handshake channel interfaces for branch items, prediction items and the threshold register
interface pbp_req_if import pbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] branch_address;
   logic                 taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface pbp_rsp_if import pbp_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      predicted_taken;
   logic      correct;
   shown_type perceptron_sum;

   modport source (output valid, output predicted_taken, output correct,
                   output perceptron_sum, input ready);
   modport sink   (input valid, input predicted_taken, input correct,
                   input perceptron_sum, output ready);
endinterface

interface pbp_csr_if import pbp_pkg::*; ();
   logic    valid;
   logic    ready;
   thr_type train_threshold;

   modport source (output valid, output train_threshold, input ready);
   modport sink   (input valid, input train_threshold, output ready);
endinterface

[hdl/perceptron_branch_predictor.sv]
// perceptron_branch_predictor: top level with sequencer, history, threshold and result register
//
//   channel  dir  handshake          payload
//   req_ch   in   valid / ready      branch_address[31:0], taken
//   rsp_ch   out  valid / ready      predicted_taken, correct, perceptron_sum[11:0] signed
//   csr_ch   in   valid / ready      train_threshold[7:0]
//
// an item goes through accept plus table read, sum, then update and result load
// the next item is accepted in the cycle after the update, set by the table read-modify-write
// the result register lets the next item in while a result waits; the update stage holds
// only when that register is still full
// reset clears the history, the threshold to 30 and the table valid bits at once
// the threshold port is always ready
module perceptron_branch_predictor import pbp_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   pbp_req_if.sink   req_ch,
   pbp_rsp_if.source rsp_ch,
   pbp_csr_if.sink   csr_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_UPDATE
   } state_type;

   state_type   state_ff, state_in;
   hist_type    history_ff, history_in;
   thr_type     threshold_ff, threshold_in;
   idx_type     idx_ff, idx_in;
   logic        taken_ff, taken_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        pred_ff, pred_in;
   logic        correct_ff, correct_in;
   shown_type   shown_ff, shown_in;

   logic        req_fire;
   logic        slot_free;
   logic        update_go;
   row_type     rd_row;
   row_type     new_row;
   sum_type     sum;
   verdict_type verdict;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid & req_ch.ready;
   // result register empty or being emptied this cycle
   assign slot_free    = ~rsp_valid_ff | rsp_ch.ready;
   assign update_go    = (state_ff == ST_UPDATE) & slot_free;

   // row storage, read on accept and written back after training
   pbp_table u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_fire),
      .rd_idx (req_ch.branch_address[IDX_BITS-1:0]),
      .rd_row (rd_row),
      .wr_en  (update_go & verdict.train),
      .wr_idx (idx_ff),
      .wr_row (new_row)
   );

   // dot product in the sum state, decision and new row in the update state
   pbp_neuron u_neuron (
      .clock     (clock),
      .load      (state_ff == ST_SUM),
      .rd_row    (rd_row),
      .history   (history_ff),
      .taken     (taken_ff),
      .threshold (threshold_ff),
      .sum       (sum),
      .verdict   (verdict),
      .new_row   (new_row)
   );

   always_comb begin
      state_in     = state_ff;
      history_in   = history_ff;
      threshold_in = threshold_ff;
      idx_in       = idx_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      pred_in      = pred_ff;
      correct_in   = correct_ff;
      shown_in     = shown_ff;

      if (csr_ch.valid & csr_ch.ready) begin
         threshold_in = csr_ch.train_threshold;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in   = req_ch.branch_address[IDX_BITS-1:0];
               taken_in = req_ch.taken;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               pred_in      = verdict.pred;
               correct_in   = (verdict.pred == taken_ff);
               shown_in     = clamp_sum(sum);
               // newest outcome enters at bit 0
               history_in   = HISTORY_LENGTH'({history_ff, taken_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         history_ff   <= '0;
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         history_ff   <= history_in;
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      taken_ff   <= taken_in;
      pred_ff    <= pred_in;
      correct_ff <= correct_in;
      shown_ff   <= shown_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.predicted_taken = pred_ff;
   assign rsp_ch.correct         = correct_ff;
   assign rsp_ch.perceptron_sum  = shown_ff;

   // an accepted item always moves on to the sum state
   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SUM))
      else $error("accepted item did not reach sum state");

   // a finished update always leaves a result in the output register
   a_update_loads_result: assert property (@(posedge clock) disable iff (reset)
      update_go |=> rsp_valid_ff)
      else $error("update finished without a result");

   // the shown sum keeps the sign that made the prediction
   a_pred_matches_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pred_ff == ~shown_ff[OUT_BITS-1]))
      else $error("prediction disagrees with sum sign");

   // the outcome of the finished item is shifted into the history
   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      update_go |=> (history_ff[0] == $past(taken_ff)))
      else $error("history did not take the outcome");

endmodule

[hdl/pbp_table.sv]
// pbp_table: perceptron row memory with registered read and per-row valid bits
module pbp_table import pbp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    rd_en,
   input  idx_type rd_idx,
   output row_type rd_row,
   input  logic    wr_en,
   input  idx_type wr_idx,
   input  row_type wr_row
);

   row_type                    mem [TABLE_ENTRIES];
   row_type                    data_ff;
   logic                       hit_ff;
   logic [TABLE_ENTRIES-1:0]   valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_row;
      end
      if (rd_en) begin
         data_ff <= mem[rd_idx];
         hit_ff  <= valid_ff[rd_idx];
      end
   end

   // a row never written since reset reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_row = hit_ff ? data_ff : '0;

endmodule

[hdl/pbp_neuron.sv]
// pbp_neuron: perceptron dot product, training decision and row update
module pbp_neuron import pbp_pkg::*; (
   input  logic        clock,
   input  logic        load,
   input  row_type     rd_row,
   input  hist_type    history,
   input  logic        taken,
   input  thr_type     threshold,
   output sum_type     sum,
   output verdict_type verdict,
   output row_type     new_row
);

   sum_type                    acc;
   sum_type                    sum_ff;
   row_type                    row_ff;
   logic                       pred;
   logic [SUM_BITS-1:0]        mag;
   logic [SUM_BITS+THR_BITS-1:0] mag_w;
   logic [SUM_BITS+THR_BITS-1:0] thr_w;

   // bias plus weights signed by history bits
   always_comb begin
      acc = sum_type'(rd_row.bias);
      for (int j = 0; j < HISTORY_LENGTH; j++) begin
         if (history[j]) acc = acc + sum_type'(rd_row.weight[j]);
         else            acc = acc - sum_type'(rd_row.weight[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= acc;
         row_ff <= rd_row;
      end
   end

   assign pred  = ~sum_ff[SUM_BITS-1];
   assign mag   = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign mag_w = (SUM_BITS+THR_BITS)'(mag);
   assign thr_w = (SUM_BITS+THR_BITS)'(threshold);

   assign verdict.pred  = pred;
   assign verdict.train = (pred != taken) || (mag_w <= thr_w);

   always_comb begin
      new_row.bias = sat_step(row_ff.bias, taken);
      for (int j = 0; j < HISTORY_LENGTH; j++) begin
         new_row.weight[j] = sat_step(row_ff.weight[j], history[j] == taken);
      end
   end

   assign sum = sum_ff;

endmodule

[sim/prediction_checker.sv]
`timescale 1ns / 100ps
// prediction_checker: watches the branch, prediction and threshold channels, predicts and compares
module prediction_checker import pbp_pkg::*; (
   input  logic clock,
   input  logic reset,
   pbp_req_if   req_mon,
   pbp_rsp_if   rsp_mon,
   pbp_csr_if   csr_mon,
   output int   mismatches,
   output int   outstanding
);

   typedef struct packed {
      logic      predicted_taken;
      logic      correct;
      shown_type perceptron_sum;
   } prediction_type;

   localparam int SHOWN_HI = (1 << (OUT_BITS - 1)) - 1;
   localparam int SHOWN_LO = -(1 << (OUT_BITS - 1));

   weight_type     weights [TABLE_ENTRIES][HISTORY_LENGTH];
   weight_type     biases  [TABLE_ENTRIES];
   hist_type       history;
   thr_type        threshold;
   prediction_type predictions_due[$];

   initial mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // append one expected result item at the tail of the pending list
   task automatic enqueue_prediction(input prediction_type p);
      predictions_due.insert(predictions_due.size(), p);
   endtask

   // one training step, held at the weight limits
   function automatic weight_type nudge(weight_type w, logic up);
      int v;
      v = int'(w) + (up ? 1 : -1);
      if (v > int'(WEIGHT_MAX)) v = int'(WEIGHT_MAX);
      if (v < int'(WEIGHT_MIN)) v = int'(WEIGHT_MIN);
      return weight_type'(v);
   endfunction

   // expected prediction for one branch; trains on a miss or weak sum, shifts the history
   function automatic prediction_type predict_and_train(logic [ADDR_BITS-1:0] addr, logic tk);
      idx_type        row;
      int             sum;
      int             mag;
      int             shown;
      int             j;
      logic           guess;
      prediction_type p;
      row = idx_type'(addr % TABLE_ENTRIES);
      sum = int'(biases[row]);
      for (j = 0; j < HISTORY_LENGTH; j++)
         sum += history[j] ? int'(weights[row][j]) : -int'(weights[row][j]);
      guess = (sum >= 0);
      mag   = guess ? sum : -sum;
      if (guess != tk || mag <= int'(threshold)) begin
         biases[row] = nudge(biases[row], tk);
         for (j = 0; j < HISTORY_LENGTH; j++)
            weights[row][j] = nudge(weights[row][j], history[j] == tk);
      end
      history = hist_type'({history, tk});
      shown = sum;
      if (shown > SHOWN_HI) shown = SHOWN_HI;
      if (shown < SHOWN_LO) shown = SHOWN_LO;
      p.predicted_taken = guess;
      p.correct         = (guess == tk);
      p.perceptron_sum  = shown_type'(shown);
      return p;
   endfunction

   always @(posedge clock) begin
      prediction_type got;
      prediction_type want;
      int             r;
      int             j;
      if (reset) begin
         history   = '0;
         threshold = THRESHOLD_RESET;
         for (r = 0; r < TABLE_ENTRIES; r++) begin
            biases[r] = '0;
            for (j = 0; j < HISTORY_LENGTH; j++)
               weights[r][j] = '0;
         end
         predictions_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            threshold = csr_mon.train_threshold;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.predicted_taken = rsp_mon.predicted_taken;
            got.correct         = rsp_mon.correct;
            got.perceptron_sum  = rsp_mon.perceptron_sum;
            if (predictions_due.size() == 0) begin
               report_mismatch("result item with no prediction pending");
            end else begin
               want = predictions_due.pop_front();
               if (got.predicted_taken !== want.predicted_taken)
                  report_mismatch($sformatf("predicted_taken got %0b want %0b",
                                            got.predicted_taken, want.predicted_taken));
               if (got.correct !== want.correct)
                  report_mismatch($sformatf("correct got %0b want %0b",
                                            got.correct, want.correct));
               if (got.perceptron_sum !== want.perceptron_sum)
                  report_mismatch($sformatf("perceptron_sum got %0d want %0d",
                                            got.perceptron_sum, want.perceptron_sum));
            end
         end
         if (req_mon.valid && req_mon.ready)
            enqueue_prediction(predict_and_train(req_mon.branch_address, req_mon.taken));
      end
      outstanding <= predictions_due.size();
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// testbench: branch stimulus, threshold phases and verdict for the perceptron branch predictor
module testbench import pbp_pkg::*; ();

   // far above the slowest correct run of under a thousand items
   localparam int RUN_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   items_sent = 0;
   bit   quiet = 1'b0;       // last phase: no gaps on either side
   logic last_taken = 1'b0;  // outcome of the most recent branch sent
   int   mismatches;
   int   outstanding;

   pbp_req_if req_bus ();
   pbp_rsp_if rsp_bus ();
   pbp_csr_if csr_bus ();

   perceptron_branch_predictor i_dut (
      .clock,
      .reset,
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   prediction_checker i_checker (
      .clock,
      .reset,
      .req_mon (req_bus),
      .rsp_mon (rsp_bus),
      .csr_mon (csr_bus),
      .mismatches,
      .outstanding
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // offer one branch item, entered and left at a falling edge
   task automatic send_branch(input logic [ADDR_BITS-1:0] addr, input logic tk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         // short gap before this item
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.branch_address <= addr;
      req_bus.taken          <= tk;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      last_taken = tk;
      items_sent++;
      @(negedge clock);
   endtask

   // stop offering, wait for every pending prediction, then let the pipe settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // threshold write, only with the block idle
   task automatic write_threshold(input thr_type value);
      drain();
      csr_bus.train_threshold <= value;
      csr_bus.valid           <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // receiver: random stall bursts, one long hold-off so the block backs up
   initial begin
      bit hold_done;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= 40) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (80) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [ADDR_BITS-1:0] pool_addr [8];
      logic                 pool_dir  [8];
      logic [ADDR_BITS-1:0] follow_addr;
      logic [ADDR_BITS-1:0] flip_addr;
      logic [ADDR_BITS-1:0] steady_addr;
      int                   k;

      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.branch_address  = '0;
      req_bus.taken           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.train_threshold = '0;

      // a few recurring branches, two of them sharing one table entry
      for (k = 0; k < 8; k++) begin
         pool_addr[k] = $urandom();
         pool_dir[k]  = 1'($urandom_range(0, 1));
      end
      pool_addr[1][IDX_BITS-1:0] = pool_addr[0][IDX_BITS-1:0];

      // fixed entries for the saturation phase
      follow_addr = $urandom();
      flip_addr   = $urandom();
      steady_addr = $urandom();
      follow_addr[IDX_BITS-1:0] = idx_type'(1);
      flip_addr[IDX_BITS-1:0]   = idx_type'(2);
      steady_addr[IDX_BITS-1:0] = idx_type'(3);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items at the reset threshold: address extremes and aliases
      send_branch('0, 1'b1);
      send_branch('0, 1'b0);
      send_branch('1, 1'b1);
      send_branch('1, 1'b0);
      send_branch(32'h0000_0040, 1'b1);   // same entry as address zero
      send_branch(32'h8000_003F, 1'b0);   // same entry as all ones
      send_branch(32'h8000_0000, 1'b1);
      send_branch(32'h7FFF_FFFF, 1'b0);
      // back-to-back updates of one entry, then a change of direction
      repeat (6) send_branch(32'h0000_1234, 1'b1);
      repeat (3) send_branch(32'h0000_1234, 1'b0);
      for (k = 0; k < 4; k++)
         send_branch(32'hAAAA_5555, k[0]);

      // zero threshold: training only on a wrong prediction or a zero sum
      write_threshold('0);
      repeat (80) begin
         if ($urandom_range(0, 3) == 0) begin
            send_branch($urandom(), 1'($urandom_range(0, 1)));
         end else begin
            k = $urandom_range(0, 7);
            send_branch(pool_addr[k], ($urandom_range(0, 9) < 8) ? pool_dir[k] : !pool_dir[k]);
         end
      end

      // top threshold: keeps training so weights and bias run into their limits
      //   follow entry copies the last outcome, its first weight climbs to the top
      //   flip entry inverts it, its first weight sinks to the bottom
      //   steady entry is always taken at uneven spacing, its bias climbs
      write_threshold('1);
      repeat (100) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 4))
               0:       send_branch($urandom(), 1'($urandom_range(0, 1)));
               1, 2:    send_branch(follow_addr, last_taken);
               default: send_branch(flip_addr, !last_taken);
            endcase
         end
         send_branch(steady_addr, 1'b1);
      end

      // mid-range threshold, back to mixed branches, no gaps to the end
      write_threshold(thr_type'($urandom_range(1, 254)));
      quiet = 1'b1;
      repeat (50) begin
         k = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0)
            send_branch($urandom(), 1'($urandom_range(0, 1)));
         else
            send_branch(pool_addr[k], ($urandom_range(0, 9) < 8) ? pool_dir[k] : !pool_dir[k]);
      end

      drain();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
hdl/pbp_pkg.sv
hdl/pbp_if.sv
hdl/pbp_table.sv
hdl/pbp_neuron.sv
hdl/perceptron_branch_predictor.sv
sim/prediction_checker.sv
sim/testbench.sv
